FILE: sv/spra_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the spi register access slave
// no dependencies; the fifo, front, back and top files use these by scoped name

package spra_pkg;

  // register store geometry
  localparam int STORE_ADDR_BITS = 12;
  localparam int ADDR_BITS       = 16;
  localparam int DATA_BITS       = 8;

  // command decoding
  localparam logic [2:0] OP_WRITE = 3'b010;
  localparam logic [2:0] OP_READ  = 3'b011;
  localparam logic [2:0] POS_DATA = 3'd4;

  // input item kinds
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // queue between front and back
  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_PTR_BITS = 1;

  // one classified beat, as handed from front to back
  typedef struct packed {
    logic                     is_data;
    logic                     is_write;
    logic                     in_range;
    logic [ADDR_BITS-1:0]     addr;
    logic [DATA_BITS-1:0]     wdata;
  } spra_op_t;

  // back-end status seen by the front
  typedef struct packed {
    logic clear_busy;
  } spra_status_t;

endpackage

FILE: sv/spra_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module spra_ram #(
  parameter int WIDTH     = 8,
  parameter int ADDR_BITS = 12
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/spra_fifo.sv
`timescale 1ns / 1ps
// short queue of classified beats between front and back
// depends on spra_pkg

module spra_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  spra_pkg::spra_op_t push_op,
  output logic              full,
  input  logic              pop,
  output spra_pkg::spra_op_t pop_op,
  output logic              empty
);

  spra_pkg::spra_op_t                    entries [spra_pkg::QUEUE_DEPTH];
  logic [spra_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr;
  logic [spra_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr;
  logic [spra_pkg::QUEUE_PTR_BITS:0]     count;

  assign full   = (count == (spra_pkg::QUEUE_PTR_BITS + 1)'(spra_pkg::QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign pop_op = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
`endif

endmodule

FILE: sv/spra_front.sv
`timescale 1ns / 1ps
// front end: accepts spi beats, tracks the frame and classifies each beat
// depends on spra_pkg

module spra_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  kind,
  input  logic [7:0]            mosi_byte,
  input  spra_pkg::spra_status_t status,
  input  logic                  q_full,
  output logic                  q_push,
  output spra_pkg::spra_op_t    q_op
);

  logic [2:0]                       byte_position;
  logic [2:0]                       opcode;
  logic [spra_pkg::ADDR_BITS-1:0]   current_address;
  logic [2:0]                       byte_position_next;
  logic [2:0]                       opcode_next;
  logic [spra_pkg::ADDR_BITS-1:0]   current_address_next;

  assign in_ready = !q_full && !status.clear_busy;
  assign q_push   = in_valid && in_ready;

  // frame decoding and beat classification
  always_comb begin
    byte_position_next   = byte_position;
    opcode_next          = opcode;
    current_address_next = current_address;
    q_op                 = '0;
    if (kind == spra_pkg::KIND_RELEASE) begin
      byte_position_next   = '0;
      opcode_next          = '0;
      current_address_next = '0;
    end else if (byte_position < spra_pkg::POS_DATA) begin
      case (byte_position)
        3'd0: begin
          opcode_next          = mosi_byte[7:5];
          current_address_next = '0;
        end
        3'd1: begin
          current_address_next = {mosi_byte[4:0], 11'b0};
        end
        3'd2: begin
          current_address_next = current_address | {5'b0, mosi_byte, 3'b0};
        end
        default: begin
          current_address_next = current_address | {13'b0, mosi_byte[7:5]};
        end
      endcase
      byte_position_next = byte_position + 3'd1;
    end else if (opcode == spra_pkg::OP_WRITE || opcode == spra_pkg::OP_READ) begin
      q_op.is_data         = 1'b1;
      q_op.is_write        = (opcode == spra_pkg::OP_WRITE);
      q_op.in_range        = ((32'(current_address) >> spra_pkg::STORE_ADDR_BITS) == 32'd0);
      q_op.addr            = current_address;
      q_op.wdata           = mosi_byte;
      current_address_next = current_address + 1'b1;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      opcode          <= '0;
      current_address <= '0;
    end else if (q_push) begin
      byte_position   <= byte_position_next;
      opcode          <= opcode_next;
      current_address <= current_address_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
      status.clear_busy |-> !q_push)
    else $error("beat accepted during store clear");
`endif

endmodule

FILE: sv/spra_back.sv
`timescale 1ns / 1ps
// back end: clears the store after reset, performs reads and writes, holds the result beat
// depends on spra_pkg and spra_ram

module spra_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  spra_pkg::spra_op_t    q_op,
  output logic                  q_pop,
  output spra_pkg::spra_status_t status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            miso_byte,
  output logic                  data_phase,
  output logic [15:0]           access_address,
  output logic                  wrote
);

  logic                                   clearing;
  logic [spra_pkg::STORE_ADDR_BITS-1:0]   clr_addr;
  logic                                   s1_valid;
  spra_pkg::spra_op_t                     s1_op;
  logic                                   op_write;
  logic                                   ram_we;
  logic [spra_pkg::STORE_ADDR_BITS-1:0]   ram_waddr;
  logic [spra_pkg::DATA_BITS-1:0]         ram_wdata;
  logic [spra_pkg::DATA_BITS-1:0]         ram_rdata;

  assign status.clear_busy = clearing;

  // issue the next beat when the result slot frees up
  assign q_pop    = !q_empty && !clearing && (!s1_valid || out_ready);
  assign op_write = q_pop && q_op.is_data && q_op.is_write && q_op.in_range;

  // store write port: clear sweep or data write
  always_comb begin
    ram_we    = clearing || op_write;
    ram_waddr = clearing ? clr_addr : q_op.addr[spra_pkg::STORE_ADDR_BITS-1:0];
    ram_wdata = clearing ? '0 : q_op.wdata;
  end

  spra_ram #(
    .WIDTH     (spra_pkg::DATA_BITS),
    .ADDR_BITS (spra_pkg::STORE_ADDR_BITS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (q_pop),
    .raddr (q_op.addr[spra_pkg::STORE_ADDR_BITS-1:0]),
    .rdata (ram_rdata)
  );

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  // result slot
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (q_pop) begin
      s1_valid <= 1'b1;
    end else if (out_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_op <= q_op;
    end
  end

  // result fields
  assign out_valid      = s1_valid;
  assign data_phase     = s1_op.is_data;
  assign access_address = s1_op.addr;
  assign wrote          = s1_op.is_data && s1_op.is_write && s1_op.in_range;
  assign miso_byte      = (s1_op.is_data && !s1_op.is_write && s1_op.in_range) ?
                          ram_rdata : '0;

`ifndef NO_ASSERTIONS
  a_no_issue_in_clear: assert property (@(posedge clk) disable iff (rst)
      clearing |-> !q_pop && !s1_valid)
    else $error("beat issued during store clear");
  a_clear_full_sweep: assert property (@(posedge clk) disable iff (rst)
      $fell(clearing) |-> $past(clr_addr) == '1)
    else $error("store clear ended early");
  a_addr_only_on_data: assert property (@(posedge clk) disable iff (rst)
      s1_valid && !s1_op.is_data |-> s1_op.addr == '0 && !wrote && miso_byte == '0)
    else $error("non-data beat carries access fields");
`endif

endmodule

FILE: sv/spi_register_access_slave_unit.sv
`timescale 1ns / 1ps
// an accepted beat is stored in the queue, then issued into the result slot.
// throughput: one beat per cycle while m_tready is high and no clear runs; a read uses
// the store's single read port; its data is registered there as the next beat issues.
// reset: frame state clears at once; the register store is then swept to zero across
// all 4096 addresses (2**STORE_ADDR_BITS), with s_tready low until the sweep ends.
// top level: front classifier, two-entry queue, back end with the register store

module spi_register_access_slave_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] mosi_byte
  input  logic        s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] miso_byte, [23:8] access_address
  output logic [1:0]  m_tuser    // [0] data_phase, [1] wrote
);

  logic                   q_push;
  logic                   q_full;
  logic                   q_pop;
  logic                   q_empty;
  spra_pkg::spra_op_t     push_op;
  spra_pkg::spra_op_t     pop_op;
  spra_pkg::spra_status_t status;
  logic [7:0]             miso_byte;
  logic                   data_phase;
  logic [15:0]            access_address;
  logic                   wrote;

  spra_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .kind      (s_tuser),
    .mosi_byte (s_tdata),
    .status    (status),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_op      (push_op)
  );

  spra_fifo u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (q_pop),
    .pop_op  (pop_op),
    .empty   (q_empty)
  );

  spra_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_op           (pop_op),
    .q_pop          (q_pop),
    .status         (status),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .miso_byte      (miso_byte),
    .data_phase     (data_phase),
    .access_address (access_address),
    .wrote          (wrote)
  );

  // pack the result beat
  assign m_tdata = {access_address, miso_byte};
  assign m_tuser = {wrote, data_phase};

endmodule
